// File: rtl/xxh_pkg.sv
// Package with the xxHash constants, datapath command codes and control types.
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  localparam int unsigned StripeBytes = 32;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_INSERT,
    OP_LOAD,
    OP_RND_A,
    OP_RND_B,
    OP_FOLD_END,
    OP_H_SHORT,
    OP_H_LONG0,
    OP_H_LACC,
    OP_MRG_A,
    OP_MRG_B,
    OP_MRG_C,
    OP_H_LEN,
    OP_T8_A,
    OP_T8_C,
    OP_T4_A,
    OP_T4_B,
    OP_T1_A,
    OP_T1_B,
    OP_AV1,
    OP_AV_M2,
    OP_AV2,
    OP_AV_M3,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic       take;
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic more;
    logic last;
    logic long_mode;
    logic tail8;
    logic tail4;
    logic tail1;
    logic mul_busy;
    logic mul_done;
    logic out_busy;
  } sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic logic is_mul_op(input op_e op);
    logic res;
    case (op)
      OP_RND_A, OP_RND_B, OP_MRG_A, OP_MRG_B, OP_MRG_C, OP_T8_A, OP_T8_C,
      OP_T4_A, OP_T4_B, OP_T1_A, OP_T1_B, OP_AV_M2, OP_AV_M3: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/xxh_if.sv
// Stream and configuration channel interfaces of the hash unit.
`default_nettype none
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

interface xxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;
  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface
`default_nettype wire

// File: rtl/xxh64_stream_hash_unit.sv
// Top level of the streaming 64-bit xxHash unit.
//
// Message bytes arrive on in_chan, up to eight per item, first byte in bits
// 7:0, with byte_count giving the valid bytes and last closing the message.
// The 64-bit digest of each message leaves on out_chan as one item. The user must
// write the seed via cfg_chan (always ready) only while idle; the unit won't check.
//
// The unit works on one item at a time, accepting, inserting and checking it in
// turn. Each full stripe costs four lane rounds of two multiplies; every
// multiply runs on one shared 32x32 unit as issue, three partial products and
// write back. Finalization takes the short or the long path, then handles
// each 8-byte, 4-byte and single-byte tail piece in turn.
//
// The digest sits in an output register; the unit keeps taking new items
// while it waits, and stalls only when a second digest is ready before the
// first was taken. Reset clears the seed to zero and empties all message
// state; the stripe buffer needs no clearing since unwritten bytes are never read.
`default_nettype none
module xxh64_stream_hash_unit #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xxh_in_if.sink     in_chan,
  xxh_out_if.source  out_chan,
  xxh_cfg_if.sink    cfg_chan
);
  xxh_pkg::cmd_t cmd;
  xxh_pkg::sts_t sts;

  // Seed writes are always taken.
  assign cfg_chan.ready = 1'b1;

  xxh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xxh_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_chan.valid),
    .cfg_seed_i   (cfg_chan.seed),
    .data_word_i  (in_chan.data_word),
    .byte_count_i (in_chan.byte_count),
    .last_i       (in_chan.last),
    .out_valid_o  (out_chan.valid),
    .out_ready_i  (out_chan.ready),
    .digest_o     (out_chan.digest)
  );

  // A full stripe is always folded before the next item is taken.
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan.ready |-> !sts.full) else $error("item taken with a full stripe");

  // The shared multiplier is never restarted while it is working.
  a_mul_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xxh_pkg::is_mul_op(cmd.op) |-> !sts.mul_busy)
    else $error("multiply issued while busy");

  // A digest never overwrites one that was not yet taken.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == xxh_pkg::OP_EMIT) |-> !sts.out_busy)
    else $error("digest overwritten");
endmodule
`default_nettype wire

// File: rtl/xxh_mul.sv
// Iterative 64x64 multiplier, low 64 bits, one 32x32 partial product per cycle.
`default_nettype none
module xxh_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      prod_o
);
  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  always_comb begin
    op_a = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
    op_b = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
    pp   = {32'd0, op_a} * {32'd0, op_b};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      case (step_q)
        2'd0:    acc_q <= pp;
        default: acc_q <= acc_q + {pp[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          step_q <= 2'd0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

// File: rtl/xxh_dp.sv
// Datapath: stripe buffer, lanes, hash registers, shared multiplier and output register.
`default_nettype none
module xxh_dp #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xxh_pkg::cmd_t     cmd_i,
  output xxh_pkg::sts_t          sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [63:0]       cfg_seed_i,
  input  wire logic [63:0]       data_word_i,
  input  wire logic [3:0]        byte_count_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [63:0]            digest_o
);
  logic [63:0]                 seed_q;
  logic [3:0][63:0]            lane_q;
  logic [3:0][7:0][7:0]        buf_q, buf_d;
  logic [5:0]                  fill_q, fill_d;
  logic [LENGTH_BITS-1:0]      len_q, len_d;
  logic                        long_q;
  logic [63:0]                 data_q;
  logic [3:0]                  cnt_q, k_q;
  logic                        last_q;
  logic [63:0]                 h_q, t_q;
  logic [4:0]                  pos_q;
  xxh_pkg::op_e                op_q;
  logic [1:0]                  idx_q;
  logic [63:0]                 digest_q;
  logic                        ovalid_q;

  logic        mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_b, prod;
  logic [1:0]  lane_addr, buf_addr;
  logic [63:0] lane_rd, word_rd;
  logic [5:0]  avail, take_n, src;
  logic [3:0]  rem;
  logic        tail_op;

  xxh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // One read address per small register array.
  always_comb begin
    lane_addr = mul_done ? idx_q : cmd_i.idx;
    lane_rd   = lane_q[lane_addr];
    tail_op   = (cmd_i.op == xxh_pkg::OP_T8_A) || (cmd_i.op == xxh_pkg::OP_T4_A) ||
                (cmd_i.op == xxh_pkg::OP_T1_A);
    buf_addr  = tail_op ? pos_q[4:3] : cmd_i.idx;
    word_rd   = buf_q[buf_addr];
  end

  // Operand selection for the multiplier at issue time.
  always_comb begin
    mul_start = xxh_pkg::is_mul_op(cmd_i.op);
    mul_a     = h_q;
    mul_b     = xxh_pkg::PRIME1;
    case (cmd_i.op)
      xxh_pkg::OP_RND_A: begin mul_a = word_rd; mul_b = xxh_pkg::PRIME2; end
      xxh_pkg::OP_RND_B: begin mul_a = t_q; end
      xxh_pkg::OP_MRG_A: begin mul_a = lane_rd; mul_b = xxh_pkg::PRIME2; end
      xxh_pkg::OP_MRG_B: begin mul_a = t_q; end
      xxh_pkg::OP_T8_A:  begin mul_a = word_rd; mul_b = xxh_pkg::PRIME2; end
      xxh_pkg::OP_T8_C:  begin mul_a = xxh_pkg::rotl64(h_q, 6'd27); end
      xxh_pkg::OP_T4_A:  begin mul_a = {32'd0, word_rd[31:0]}; end
      xxh_pkg::OP_T4_B:  begin
        mul_a = xxh_pkg::rotl64(h_q, 6'd23);
        mul_b = xxh_pkg::PRIME2;
      end
      xxh_pkg::OP_T1_A:  begin
        mul_a = {56'd0, word_rd[{pos_q[2:0], 3'b000} +: 8]};
        mul_b = xxh_pkg::PRIME5;
      end
      xxh_pkg::OP_T1_B:  begin mul_a = xxh_pkg::rotl64(h_q, 6'd11); end
      xxh_pkg::OP_AV_M2: begin mul_b = xxh_pkg::PRIME2; end
      xxh_pkg::OP_AV_M3: begin mul_b = xxh_pkg::PRIME3; end
      default: begin end
    endcase
  end

  // Byte insertion: as many item bytes as fit go in after the buffered ones.
  always_comb begin
    avail  = 6'(xxh_pkg::StripeBytes) - fill_q;
    rem    = cnt_q - k_q;
    take_n = ({2'd0, rem} < avail) ? {2'd0, rem} : avail;
    buf_d  = buf_q;
    src    = 6'd0;
    for (int j = 0; j < 32; j++) begin
      src = 6'(j) - fill_q + {2'd0, k_q};
      if ((6'(j) >= fill_q) && (6'(j) < fill_q + take_n)) begin
        buf_d[j / 8][j % 8] = data_q[{src[2:0], 3'b000} +: 8];
      end
    end
    fill_d = fill_q + take_n;
    len_d  = len_q + LENGTH_BITS'(take_n);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_q <= data_word_i;
      last_q <= last_i;
      cnt_q  <= (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
      k_q    <= 4'd0;
    end
    if (mul_start) begin
      op_q  <= cmd_i.op;
      idx_q <= cmd_i.idx;
    end
    case (cmd_i.op)
      xxh_pkg::OP_INSERT: begin
        buf_q <= buf_d;
        k_q   <= k_q + take_n[3:0];
      end
      xxh_pkg::OP_LOAD: begin
        lane_q[0] <= seed_q + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
        lane_q[1] <= seed_q + xxh_pkg::PRIME2;
        lane_q[2] <= seed_q;
        lane_q[3] <= seed_q - xxh_pkg::PRIME1;
      end
      xxh_pkg::OP_H_SHORT: h_q <= seed_q + xxh_pkg::PRIME5;
      xxh_pkg::OP_H_LONG0: h_q <= xxh_pkg::rotl64(lane_rd, 6'd1);
      xxh_pkg::OP_H_LACC: begin
        case (cmd_i.idx)
          2'd1:    h_q <= h_q + xxh_pkg::rotl64(lane_rd, 6'd7);
          2'd2:    h_q <= h_q + xxh_pkg::rotl64(lane_rd, 6'd12);
          default: h_q <= h_q + xxh_pkg::rotl64(lane_rd, 6'd18);
        endcase
      end
      xxh_pkg::OP_H_LEN: begin
        h_q   <= h_q + 64'(len_q);
        pos_q <= 5'd0;
      end
      xxh_pkg::OP_AV1:  h_q <= h_q ^ (h_q >> 33);
      xxh_pkg::OP_AV2:  h_q <= h_q ^ (h_q >> 29);
      xxh_pkg::OP_EMIT: digest_q <= h_q ^ (h_q >> 32);
      default: begin end
    endcase
    // Results of the multiplier are applied when it reports done.
    if (mul_done) begin
      case (op_q)
        xxh_pkg::OP_RND_A: t_q <= xxh_pkg::rotl64(lane_rd + prod, 6'd31);
        xxh_pkg::OP_RND_B: lane_q[idx_q] <= prod;
        xxh_pkg::OP_MRG_A, xxh_pkg::OP_T8_A: t_q <= xxh_pkg::rotl64(prod, 6'd31);
        xxh_pkg::OP_MRG_B, xxh_pkg::OP_T4_A, xxh_pkg::OP_T1_A: h_q <= h_q ^ prod;
        xxh_pkg::OP_MRG_C: h_q <= prod + xxh_pkg::PRIME4;
        xxh_pkg::OP_T8_C: begin
          h_q   <= prod + xxh_pkg::PRIME4;
          pos_q <= pos_q + 5'd8;
        end
        xxh_pkg::OP_T4_B: begin
          h_q   <= prod + xxh_pkg::PRIME3;
          pos_q <= pos_q + 5'd4;
        end
        xxh_pkg::OP_T1_B: begin
          h_q   <= prod;
          pos_q <= pos_q + 5'd1;
        end
        default: h_q <= prod;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= 64'd0;
      fill_q   <= 6'd0;
      len_q    <= '0;
      long_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_seed_i;
      end
      if (out_valid_o && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      case (cmd_i.op)
        xxh_pkg::OP_INSERT: begin
          fill_q <= fill_d;
          len_q  <= len_d;
        end
        xxh_pkg::OP_FOLD_END: begin
          long_q <= 1'b1;
          fill_q <= 6'd0;
        end
        xxh_pkg::OP_EMIT: begin
          ovalid_q <= 1'b1;
          fill_q   <= 6'd0;
          len_q    <= '0;
          long_q   <= 1'b0;
        end
        default: begin end
      endcase
    end
  end

  always_comb begin
    sts_o.full      = (fill_q == 6'(xxh_pkg::StripeBytes));
    sts_o.more      = (k_q < cnt_q);
    sts_o.last      = last_q;
    sts_o.long_mode = long_q;
    sts_o.tail8     = ({1'b0, pos_q} + 6'd8) <= fill_q;
    sts_o.tail4     = ({1'b0, pos_q} + 6'd4) <= fill_q;
    sts_o.tail1     = {1'b0, pos_q} < fill_q;
    sts_o.mul_busy  = mul_busy;
    sts_o.mul_done  = mul_done;
    sts_o.out_busy  = ovalid_q;
  end

  assign out_valid_o = ovalid_q;
  assign digest_o    = digest_q;
endmodule
`default_nettype wire

// File: rtl/xxh_ctrl.sv
// Controller: sequences insertion, stripe folding and digest finalization.
`default_nettype none
module xxh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire xxh_pkg::sts_t sts_i,
  output xxh_pkg::cmd_t      cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_INS, S_CHK, S_LOAD, S_RND_A, S_RND_B, S_FOLD, S_FIN, S_HS, S_HL0,
    S_HLACC, S_MA, S_MB, S_MC, S_HLEN, S_TSEL, S_T8A, S_T8B, S_T8C, S_T4A, S_T4B,
    S_T1A, S_T1B, S_AV1, S_M2, S_AV2, S_M3, S_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] i_q;
  logic       issued_q;
  xxh_pkg::op_e mop;
  logic       is_mul;

  // Multiplier step of each waiting state.
  always_comb begin
    is_mul = 1'b1;
    case (state_q)
      S_RND_A: mop = xxh_pkg::OP_RND_A;
      S_RND_B: mop = xxh_pkg::OP_RND_B;
      S_MA:    mop = xxh_pkg::OP_MRG_A;
      S_MB:    mop = xxh_pkg::OP_MRG_B;
      S_MC:    mop = xxh_pkg::OP_MRG_C;
      S_T8A:   mop = xxh_pkg::OP_T8_A;
      S_T8B:   mop = xxh_pkg::OP_MRG_B;
      S_T8C:   mop = xxh_pkg::OP_T8_C;
      S_T4A:   mop = xxh_pkg::OP_T4_A;
      S_T4B:   mop = xxh_pkg::OP_T4_B;
      S_T1A:   mop = xxh_pkg::OP_T1_A;
      S_T1B:   mop = xxh_pkg::OP_T1_B;
      S_M2:    mop = xxh_pkg::OP_AV_M2;
      S_M3:    mop = xxh_pkg::OP_AV_M3;
      default: begin
        mop    = xxh_pkg::OP_NOP;
        is_mul = 1'b0;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    cmd_o.take = in_valid_i && in_ready_o;
    cmd_o.idx  = i_q;
    case (state_q)
      S_INS:   cmd_o.op = xxh_pkg::OP_INSERT;
      S_LOAD:  cmd_o.op = xxh_pkg::OP_LOAD;
      S_FOLD:  cmd_o.op = xxh_pkg::OP_FOLD_END;
      S_HS:    cmd_o.op = xxh_pkg::OP_H_SHORT;
      S_HL0:   cmd_o.op = xxh_pkg::OP_H_LONG0;
      S_HLACC: cmd_o.op = xxh_pkg::OP_H_LACC;
      S_HLEN:  cmd_o.op = xxh_pkg::OP_H_LEN;
      S_AV1:   cmd_o.op = xxh_pkg::OP_AV1;
      S_AV2:   cmd_o.op = xxh_pkg::OP_AV2;
      S_EMIT:  cmd_o.op = sts_i.out_busy ? xxh_pkg::OP_NOP : xxh_pkg::OP_EMIT;
      default: cmd_o.op = (is_mul && !issued_q) ? mop : xxh_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= 2'd0;
      issued_q <= 1'b0;
    end else if (is_mul) begin
      if (!issued_q) begin
        issued_q <= 1'b1;
      end else if (sts_i.mul_done) begin
        issued_q <= 1'b0;
        case (state_q)
          S_RND_A: state_q <= S_RND_B;
          S_RND_B: begin
            i_q     <= i_q + 2'd1;
            state_q <= (i_q == 2'd3) ? S_FOLD : S_RND_A;
          end
          S_MA: state_q <= S_MB;
          S_MB: state_q <= S_MC;
          S_MC: begin
            i_q     <= i_q + 2'd1;
            state_q <= (i_q == 2'd3) ? S_HLEN : S_MA;
          end
          S_T8A: state_q <= S_T8B;
          S_T8B: state_q <= S_T8C;
          S_T4A: state_q <= S_T4B;
          S_T1A: state_q <= S_T1B;
          S_M2:  state_q <= S_AV2;
          S_M3:  state_q <= S_EMIT;
          default: state_q <= S_TSEL;
        endcase
      end
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= S_INS;
        end
        S_INS: state_q <= S_CHK;
        S_CHK: begin
          i_q <= 2'd0;
          if (sts_i.full) begin
            state_q <= sts_i.long_mode ? S_RND_A : S_LOAD;
          end else if (sts_i.more) begin
            state_q <= S_INS;
          end else if (sts_i.last) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_LOAD: state_q <= S_RND_A;
        S_FOLD: state_q <= S_CHK;
        S_FIN: begin
          i_q     <= 2'd0;
          state_q <= sts_i.long_mode ? S_HL0 : S_HS;
        end
        S_HS: state_q <= S_HLEN;
        S_HL0: begin
          i_q     <= 2'd1;
          state_q <= S_HLACC;
        end
        S_HLACC: begin
          i_q     <= i_q + 2'd1;
          state_q <= (i_q == 2'd3) ? S_MA : S_HLACC;
        end
        S_HLEN: state_q <= S_TSEL;
        S_TSEL: begin
          if (sts_i.tail8) begin
            state_q <= S_T8A;
          end else if (sts_i.tail4) begin
            state_q <= S_T4A;
          end else if (sts_i.tail1) begin
            state_q <= S_T1A;
          end else begin
            state_q <= S_AV1;
          end
        end
        S_AV1: state_q <= S_M2;
        S_AV2: state_q <= S_M3;
        S_EMIT: if (!sts_i.out_busy) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
